[rtl/rpp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, the payload type of the rotation stages and the arctangent table
// for the pivot rotation block. No dependencies.
package rpp_pkg;

  localparam int COORD_BITS    = 24;
  localparam int CORDIC_STAGES = 20;
  localparam int ANGLE_BITS    = 18;
  localparam int GUARD_BITS    = 8;

  // Angle units are 1/256 degree.
  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int ANGLE_SHIFT  = 16;           // 2^-8 degree -> 2^-24 degree

  localparam int RED_BITS  = 17;              // angle reduced to [-HALF_TURN, HALF_TURN)
  localparam int FOLD_BITS = 16;              // angle folded to [-QUARTER_TURN, QUARTER_TURN]
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int MAG_BITS  = COORD_BITS + GUARD_BITS;
  localparam int VEC_BITS  = COORD_BITS + GUARD_BITS + 2;
  localparam int SUM_BITS  = VEC_BITS + 1;
  localparam int Z_BITS    = FOLD_BITS + ANGLE_SHIFT + 1;
  localparam int ATAN_BITS = 30;

  localparam int GAIN_FRAC = 30;
  localparam int GAIN_BITS = 30;
  localparam longint unsigned GAIN_INF_Q30  = 64'd652032874;
  localparam longint unsigned GAIN_CORR_Q30 = 64'd434688583;
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = GAIN_BITS'((CORDIC_STAGES < 16) ?
      GAIN_INF_Q30 + (GAIN_CORR_Q30 >> (2 * CORDIC_STAGES)) : GAIN_INF_Q30);

  localparam longint Z_LIMIT = longint'(QUARTER_TURN) << ANGLE_SHIFT;

  typedef struct packed {
    logic signed [VEC_BITS-1:0]   x;
    logic signed [VEC_BITS-1:0]   y;
    logic signed [Z_BITS-1:0]     z;
    logic signed [COORD_BITS-1:0] pivot_x;
    logic signed [COORD_BITS-1:0] pivot_y;
  } rpp_vec_t;

  // round(atan(2^-i) in degrees * 2^24)
  function automatic logic [ATAN_BITS-1:0] atan_q24(input logic [4:0] idx);
    logic [ATAN_BITS-1:0] t;
    case (idx)
      5'd0:    t = 30'd754974720;
      5'd1:    t = 30'd445687602;
      5'd2:    t = 30'd235489088;
      5'd3:    t = 30'd119537938;
      5'd4:    t = 30'd60000934;
      5'd5:    t = 30'd30029717;
      5'd6:    t = 30'd15018523;
      5'd7:    t = 30'd7509720;
      5'd8:    t = 30'd3754917;
      5'd9:    t = 30'd1877466;
      5'd10:   t = 30'd938734;
      5'd11:   t = 30'd469367;
      5'd12:   t = 30'd234684;
      5'd13:   t = 30'd117342;
      5'd14:   t = 30'd58671;
      5'd15:   t = 30'd29335;
      5'd16:   t = 30'd14668;
      5'd17:   t = 30'd7334;
      5'd18:   t = 30'd3667;
      5'd19:   t = 30'd1833;
      5'd20:   t = 30'd917;
      5'd21:   t = 30'd458;
      5'd22:   t = 30'd229;
      5'd23:   t = 30'd115;
      5'd24:   t = 30'd57;
      5'd25:   t = 30'd29;
      5'd26:   t = 30'd14;
      5'd27:   t = 30'd7;
      5'd28:   t = 30'd4;
      5'd29:   t = 30'd2;
      5'd30:   t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

[rtl/rpp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pivot rotation block: input items and results.
// Depends on rpp_pkg.
interface rpp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rpp_pkg::COORD_BITS-1:0]   pivot_x;
  logic signed [rpp_pkg::COORD_BITS-1:0]   pivot_y;
  logic signed [rpp_pkg::COORD_BITS-1:0]   point_x;
  logic signed [rpp_pkg::COORD_BITS-1:0]   point_y;
  logic signed [rpp_pkg::ANGLE_BITS-1:0]   turn_angle;

  modport source (output valid, pivot_x, pivot_y, point_x, point_y, turn_angle,
                  input ready);
  modport sink   (input valid, pivot_x, pivot_y, point_x, point_y, turn_angle,
                  output ready);
endinterface

interface rpp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rpp_pkg::COORD_BITS-1:0]   rotated_x;
  logic signed [rpp_pkg::COORD_BITS-1:0]   rotated_y;

  modport source (output valid, rotated_x, rotated_y, input ready);
  modport sink   (input valid, rotated_x, rotated_y, output ready);
endinterface

[rtl/rotate_point_about_pivot_top.sv]
`timescale 1ns / 1ps
// Top level of the pivot rotation block: angle reduction, gain scaling, CORDIC pipeline,
// pivot add-back, rounding and saturation. Depends on rpp_pkg, rpp_if, rpp_cordic.
//
// Usage:
//   in_ch carries one item per valid/ready handshake: pivot, point (signed Q15.8) and
//   a turn angle in 1/256 degree, counter-clockwise positive. Any angle wraps modulo
//   360 degrees. out_ch returns the rotated point, rounded to nearest and saturated.
//   Each item gives exactly one result, in order.
//   From acceptance to out_ch.valid an item passes four input stages (difference and angle
//   reduction, fold, gain multiply, sign), one stage per CORDIC iteration, then
//   pivot add and round/saturate.
//   Throughput is one item per cycle while out_ch is ready; every stage is a register with
//   its own valid bit. When the receiver stalls, the result holds on out_ch and the stages
//   behind it keep filling empty slots; in_ch.ready drops only once every stage holds an
//   item. Synchronous active-low reset empties the pipeline; no item is lost from a stall.
module rotate_point_about_pivot_top (
  input  logic     clk,
  input  logic     rst_n,
  rpp_in_if.sink   in_ch,
  rpp_out_if.source out_ch
);

  // ---------------- stage P1: difference, angle reduction
  logic                                  p1_v_r;
  logic signed [rpp_pkg::DIFF_BITS-1:0]  p1_dx_r, p1_dy_r;
  logic signed [rpp_pkg::RED_BITS-1:0]   p1_ra_r;
  logic signed [rpp_pkg::COORD_BITS-1:0] p1_px_r, p1_py_r;
  logic signed [rpp_pkg::DIFF_BITS-1:0]  p1_dx_nxt, p1_dy_nxt;
  logic signed [rpp_pkg::RED_BITS-1:0]   p1_ra_nxt;
  logic signed [rpp_pkg::ANGLE_BITS:0]   aw;

  // ---------------- stage P2: fold, magnitude
  logic                                  p2_v_r;
  logic [rpp_pkg::COORD_BITS-1:0]        p2_mx_r, p2_my_r;
  logic                                  p2_nx_r, p2_ny_r;
  logic signed [rpp_pkg::FOLD_BITS-1:0]  p2_fa_r;
  logic signed [rpp_pkg::COORD_BITS-1:0] p2_px_r, p2_py_r;
  logic                                  flip;
  logic signed [rpp_pkg::FOLD_BITS-1:0]  p2_fa_nxt;
  logic signed [rpp_pkg::DIFF_BITS-1:0]  absx, absy;

  // ---------------- stage P3: gain multiply
  localparam int PROD_BITS = rpp_pkg::MAG_BITS + rpp_pkg::GAIN_BITS;
  logic                                  p3_v_r;
  logic [rpp_pkg::MAG_BITS-1:0]          p3_mx_r, p3_my_r;
  logic                                  p3_nx_r, p3_ny_r;
  logic signed [rpp_pkg::FOLD_BITS-1:0]  p3_fa_r;
  logic signed [rpp_pkg::COORD_BITS-1:0] p3_px_r, p3_py_r;
  logic [PROD_BITS-1:0]                  prod_x, prod_y;

  // ---------------- stage P4: signed vector into the CORDIC pipeline
  logic                                  p4_v_r;
  rpp_pkg::rpp_vec_t                     p4_r, p4_nxt;
  logic signed [rpp_pkg::VEC_BITS-1:0]   ex, ey;

  // ---------------- CORDIC and output stages
  logic                                  cor_in_ready, cor_out_valid;
  rpp_pkg::rpp_vec_t                     cor_out;
  logic                                  q1_v_r;
  logic signed [rpp_pkg::SUM_BITS-1:0]   q1_sx_r, q1_sy_r;
  logic signed [rpp_pkg::SUM_BITS-1:0]   offx, offy;
  logic                                  q2_v_r;
  logic signed [rpp_pkg::COORD_BITS-1:0] q2_rx_r, q2_ry_r, q2_rx_nxt, q2_ry_nxt;
  logic signed [rpp_pkg::SUM_BITS-rpp_pkg::GUARD_BITS-1:0] shx, shy;

  logic en_p1, en_p2, en_p3, en_p4, en_q1, en_q2;

  // Ready chain: a stage loads when it is empty or its item moves on.
  assign en_q2 = !q2_v_r || out_ch.ready;
  assign en_q1 = !q1_v_r || en_q2;
  assign en_p4 = !p4_v_r || cor_in_ready;
  assign en_p3 = !p3_v_r || en_p4;
  assign en_p2 = !p2_v_r || en_p3;
  assign en_p1 = !p1_v_r || en_p2;
  assign in_ch.ready = en_p1;

  // P1
  always_comb begin
    p1_dx_nxt = {in_ch.point_x[rpp_pkg::COORD_BITS-1], in_ch.point_x}
              - {in_ch.pivot_x[rpp_pkg::COORD_BITS-1], in_ch.pivot_x};
    p1_dy_nxt = {in_ch.point_y[rpp_pkg::COORD_BITS-1], in_ch.point_y}
              - {in_ch.pivot_y[rpp_pkg::COORD_BITS-1], in_ch.pivot_y};
    aw = {in_ch.turn_angle[rpp_pkg::ANGLE_BITS-1], in_ch.turn_angle};
    // One wrap is enough: the 18-bit range reaches under one and a half turns either way.
    if (aw >= (rpp_pkg::ANGLE_BITS+1)'(rpp_pkg::HALF_TURN)) begin
      p1_ra_nxt = rpp_pkg::RED_BITS'(aw - (rpp_pkg::ANGLE_BITS+1)'(rpp_pkg::FULL_TURN));
    end else if (aw < -(rpp_pkg::ANGLE_BITS+1)'(rpp_pkg::HALF_TURN)) begin
      p1_ra_nxt = rpp_pkg::RED_BITS'(aw + (rpp_pkg::ANGLE_BITS+1)'(rpp_pkg::FULL_TURN));
    end else begin
      p1_ra_nxt = rpp_pkg::RED_BITS'(aw);
    end
  end

  // P2: a half turn beyond the quarter is a negation of the difference
  always_comb begin
    flip = 1'b0;
    p2_fa_nxt = rpp_pkg::FOLD_BITS'(p1_ra_r);
    if (p1_ra_r > rpp_pkg::RED_BITS'(rpp_pkg::QUARTER_TURN)) begin
      flip = 1'b1;
      p2_fa_nxt = rpp_pkg::FOLD_BITS'(p1_ra_r - rpp_pkg::RED_BITS'(rpp_pkg::HALF_TURN));
    end else if (p1_ra_r < -rpp_pkg::RED_BITS'(rpp_pkg::QUARTER_TURN)) begin
      flip = 1'b1;
      p2_fa_nxt = rpp_pkg::FOLD_BITS'(p1_ra_r + rpp_pkg::RED_BITS'(rpp_pkg::HALF_TURN));
    end
    absx = p1_dx_r[rpp_pkg::DIFF_BITS-1] ? -p1_dx_r : p1_dx_r;
    absy = p1_dy_r[rpp_pkg::DIFF_BITS-1] ? -p1_dy_r : p1_dy_r;
  end

  // P3: round(mag * K / 2^30), ties away from zero on the magnitude
  assign prod_x = PROD_BITS'({p2_mx_r, {rpp_pkg::GUARD_BITS{1'b0}}}) * PROD_BITS'(rpp_pkg::GAIN_Q30)
                + (PROD_BITS'(1) << (rpp_pkg::GAIN_FRAC - 1));
  assign prod_y = PROD_BITS'({p2_my_r, {rpp_pkg::GUARD_BITS{1'b0}}}) * PROD_BITS'(rpp_pkg::GAIN_Q30)
                + (PROD_BITS'(1) << (rpp_pkg::GAIN_FRAC - 1));

  // P4
  always_comb begin
    ex = $signed(rpp_pkg::VEC_BITS'(p3_mx_r));
    ey = $signed(rpp_pkg::VEC_BITS'(p3_my_r));
    p4_nxt.x = p3_nx_r ? -ex : ex;
    p4_nxt.y = p3_ny_r ? -ey : ey;
    p4_nxt.z = $signed(rpp_pkg::Z_BITS'(p3_fa_r)) <<< rpp_pkg::ANGLE_SHIFT;
    p4_nxt.pivot_x = p3_px_r;
    p4_nxt.pivot_y = p3_py_r;
  end

  rpp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p4_v_r),
    .in_ready  (cor_in_ready),
    .in_data   (p4_r),
    .out_valid (cor_out_valid),
    .out_ready (en_q1),
    .out_data  (cor_out)
  );

  // Q1: add pivot back at guard precision, with the rounding half folded in
  assign offx = rpp_pkg::SUM_BITS'($signed({cor_out.pivot_x, 1'b1,
                                   {(rpp_pkg::GUARD_BITS-1){1'b0}}}));
  assign offy = rpp_pkg::SUM_BITS'($signed({cor_out.pivot_y, 1'b1,
                                   {(rpp_pkg::GUARD_BITS-1){1'b0}}}));

  // Q2: drop guard bits, saturate
  localparam int SH_BITS = rpp_pkg::SUM_BITS - rpp_pkg::GUARD_BITS;
  assign shx = q1_sx_r[rpp_pkg::SUM_BITS-1:rpp_pkg::GUARD_BITS];
  assign shy = q1_sy_r[rpp_pkg::SUM_BITS-1:rpp_pkg::GUARD_BITS];

  always_comb begin
    if (&shx[SH_BITS-1:rpp_pkg::COORD_BITS-1] || ~|shx[SH_BITS-1:rpp_pkg::COORD_BITS-1]) begin
      q2_rx_nxt = shx[rpp_pkg::COORD_BITS-1:0];
    end else begin
      q2_rx_nxt = {shx[SH_BITS-1], {(rpp_pkg::COORD_BITS-1){!shx[SH_BITS-1]}}};
    end
    if (&shy[SH_BITS-1:rpp_pkg::COORD_BITS-1] || ~|shy[SH_BITS-1:rpp_pkg::COORD_BITS-1]) begin
      q2_ry_nxt = shy[rpp_pkg::COORD_BITS-1:0];
    end else begin
      q2_ry_nxt = {shy[SH_BITS-1], {(rpp_pkg::COORD_BITS-1){!shy[SH_BITS-1]}}};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      q1_v_r <= 1'b0;
      q2_v_r <= 1'b0;
    end else begin
      if (en_p1) p1_v_r <= in_ch.valid;
      if (en_p2) p2_v_r <= p1_v_r;
      if (en_p3) p3_v_r <= p2_v_r;
      if (en_p4) p4_v_r <= p3_v_r;
      if (en_q1) q1_v_r <= cor_out_valid;
      if (en_q2) q2_v_r <= q1_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en_p1) begin
      p1_dx_r <= p1_dx_nxt;
      p1_dy_r <= p1_dy_nxt;
      p1_ra_r <= p1_ra_nxt;
      p1_px_r <= in_ch.pivot_x;
      p1_py_r <= in_ch.pivot_y;
    end
    if (en_p2) begin
      p2_mx_r <= absx[rpp_pkg::COORD_BITS-1:0];
      p2_my_r <= absy[rpp_pkg::COORD_BITS-1:0];
      p2_nx_r <= p1_dx_r[rpp_pkg::DIFF_BITS-1] ^ flip;
      p2_ny_r <= p1_dy_r[rpp_pkg::DIFF_BITS-1] ^ flip;
      p2_fa_r <= p2_fa_nxt;
      p2_px_r <= p1_px_r;
      p2_py_r <= p1_py_r;
    end
    if (en_p3) begin
      p3_mx_r <= prod_x[rpp_pkg::GAIN_FRAC +: rpp_pkg::MAG_BITS];
      p3_my_r <= prod_y[rpp_pkg::GAIN_FRAC +: rpp_pkg::MAG_BITS];
      p3_nx_r <= p2_nx_r;
      p3_ny_r <= p2_ny_r;
      p3_fa_r <= p2_fa_r;
      p3_px_r <= p2_px_r;
      p3_py_r <= p2_py_r;
    end
    if (en_p4) begin
      p4_r <= p4_nxt;
    end
    if (en_q1) begin
      q1_sx_r <= rpp_pkg::SUM_BITS'(cor_out.x) + offx;
      q1_sy_r <= rpp_pkg::SUM_BITS'(cor_out.y) + offy;
    end
    if (en_q2) begin
      q2_rx_r <= q2_rx_nxt;
      q2_ry_r <= q2_ry_nxt;
    end
  end

  assign out_ch.valid     = q2_v_r;
  assign out_ch.rotated_x = q2_rx_r;
  assign out_ch.rotated_y = q2_ry_r;

  a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
      p1_v_r |-> (p1_ra_r >= -rpp_pkg::RED_BITS'(rpp_pkg::HALF_TURN)) &&
                 (p1_ra_r <  rpp_pkg::RED_BITS'(rpp_pkg::HALF_TURN)))
    else $error("rpp: reduced angle outside half turn");

  a_folded_range: assert property (@(posedge clk) disable iff (!rst_n)
      p2_v_r |-> (p2_fa_r >= -rpp_pkg::FOLD_BITS'(rpp_pkg::QUARTER_TURN)) &&
                 (p2_fa_r <=  rpp_pkg::FOLD_BITS'(rpp_pkg::QUARTER_TURN)))
    else $error("rpp: folded angle outside quarter turn");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
      q1_v_r && en_q2 |=> q2_v_r)
    else $error("rpp: item lost between pivot add and output register");

endmodule

[rtl/rpp_cordic.sv]
`timescale 1ns / 1ps
// Unrolled CORDIC rotation pipeline: one register stage per iteration, with valid bits
// and a ready chain so bubbles collapse under stall. Depends on rpp_pkg.
module rpp_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpp_pkg::rpp_vec_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rpp_pkg::rpp_vec_t out_data
);

  localparam int N = rpp_pkg::CORDIC_STAGES;

  rpp_pkg::rpp_vec_t st_r [N];
  logic              v_r  [N];
  logic              en   [N];
  rpp_pkg::rpp_vec_t stage_in [N];
  logic              stage_v  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [rpp_pkg::VEC_BITS-1:0] dx;
    logic signed [rpp_pkg::VEC_BITS-1:0] dy;
    logic [rpp_pkg::Z_BITS-1:0]          t;
    rpp_pkg::rpp_vec_t                   st_nxt;

    if (k == 0) begin : g_first
      assign stage_in[k] = in_data;
      assign stage_v[k]  = in_valid;
    end else begin : g_next
      assign stage_in[k] = st_r[k-1];
      assign stage_v[k]  = v_r[k-1];
    end

    if (k == N - 1) begin : g_last_en
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid_en
      assign en[k] = !v_r[k] || en[k+1];
    end

    assign dx = $signed(stage_in[k].y) >>> k;
    assign dy = $signed(stage_in[k].x) >>> k;
    assign t  = rpp_pkg::Z_BITS'(rpp_pkg::atan_q24(5'(k)));

    always_comb begin
      st_nxt = stage_in[k];
      if (!stage_in[k].z[rpp_pkg::Z_BITS-1]) begin
        st_nxt.x = stage_in[k].x - dx;
        st_nxt.y = stage_in[k].y + dy;
        st_nxt.z = stage_in[k].z - t;
      end else begin
        st_nxt.x = stage_in[k].x + dx;
        st_nxt.y = stage_in[k].y - dy;
        st_nxt.z = stage_in[k].z + t;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= stage_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_data  = st_r[N-1];

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[N-1] && !out_ready |=> v_r[N-1] && $stable(st_r[N-1]))
    else $error("rpp_cordic: stalled result changed");

  a_item_enters: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> v_r[0])
    else $error("rpp_cordic: accepted item not in first stage");

  a_angle_folded: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid |-> ($signed(in_data.z) <= rpp_pkg::Z_LIMIT) &&
                   ($signed(in_data.z) >= -rpp_pkg::Z_LIMIT))
    else $error("rpp_cordic: input angle outside a quarter turn");

endmodule

[verif/rpp_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the pivot rotation block: predicts each rotated point from the
// accepted input items and compares it with what comes out. Depends on rpp_pkg, rpp_if.
module rpp_result_checker (
  input  logic clk,
  input  logic rst_n,
  rpp_in_if    in_mon,
  rpp_out_if   out_mon,
  output int   mismatch_count,
  output int   results_pending
);

  typedef struct packed {
    logic signed [rpp_pkg::COORD_BITS-1:0] x;
    logic signed [rpp_pkg::COORD_BITS-1:0] y;
  } rotated_point_t;

  localparam longint GUARD_SCALE = 64'sd1 <<< rpp_pkg::GUARD_BITS;
  localparam int     MAX_STAGES  = 32;

  // atan(2^-i) in degrees, scaled by 2^24
  longint arctan_q24 [MAX_STAGES] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  rotated_point_t predicted_points[$];
  rotated_point_t want;
  int             mismatches = 0;
  int             pending    = 0;

  assign mismatch_count  = mismatches;
  assign results_pending = pending;

  // round(v * k / 2^30), ties away from zero
  function automatic longint scale_by_gain(input longint v, input longint unsigned k);
    longint unsigned mag, hi, lo, r;
    mag = (v < 0) ? -v : v;
    hi  = mag >> 30;
    lo  = mag & 64'h3FFF_FFFF;
    r   = hi * k + ((lo * k + (64'd1 << 29)) >> 30);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [rpp_pkg::COORD_BITS-1:0] clamp_coord(input longint v);
    longint hi, lo, r;
    hi = (64'sd1 <<< (rpp_pkg::COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    r  = (v > hi) ? hi : ((v < lo) ? lo : v);
    return r[rpp_pkg::COORD_BITS-1:0];
  endfunction

  function automatic rotated_point_t rotate_about_pivot(
    input logic signed [rpp_pkg::COORD_BITS-1:0] pvx, pvy, ptx, pty,
    input logic signed [rpp_pkg::ANGLE_BITS-1:0] ang
  );
    longint px, py, x, y, z, a, dx, dy, step, rx, ry;
    longint unsigned gain;
    int n_stages, i;
    rotated_point_t res;
    px = longint'(pvx);
    py = longint'(pvy);
    n_stages = (rpp_pkg::CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES :
               ((rpp_pkg::CORDIC_STAGES < 1) ? 1 : rpp_pkg::CORDIC_STAGES);
    gain = rpp_pkg::GAIN_INF_Q30;
    if (n_stages < 16) gain += rpp_pkg::GAIN_CORR_Q30 >> (2 * n_stages);

    // wrap to [-180, 180) degrees
    a = longint'(ang);
    a = a % rpp_pkg::FULL_TURN;
    if (a < 0) a += rpp_pkg::FULL_TURN;
    if (a >= rpp_pkg::HALF_TURN) a -= rpp_pkg::FULL_TURN;

    x = (longint'(ptx) - px) * GUARD_SCALE;
    y = (longint'(pty) - py) * GUARD_SCALE;
    // take a half turn by negation so the remaining angle stays within a right angle
    if (a > rpp_pkg::QUARTER_TURN) begin
      x = -x; y = -y; a -= rpp_pkg::HALF_TURN;
    end else if (a < -rpp_pkg::QUARTER_TURN) begin
      x = -x; y = -y; a += rpp_pkg::HALF_TURN;
    end

    x = scale_by_gain(x, gain);
    y = scale_by_gain(y, gain);
    z = a <<< rpp_pkg::ANGLE_SHIFT;

    for (i = 0; i < n_stages; i++) begin
      dx   = y >>> i;
      dy   = x >>> i;
      step = arctan_q24[i[4:0]];
      if (z >= 0) begin
        x -= dx; y += dy; z -= step;
      end else begin
        x += dx; y -= dy; z += step;
      end
    end

    rx = (x + px * GUARD_SCALE + GUARD_SCALE / 2) >>> rpp_pkg::GUARD_BITS;
    ry = (y + py * GUARD_SCALE + GUARD_SCALE / 2) >>> rpp_pkg::GUARD_BITS;
    res.x = clamp_coord(rx);
    res.y = clamp_coord(ry);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result (%0d, %0d) with no item outstanding",
                   $time, out_mon.rotated_x, out_mon.rotated_y);
        end else begin
          want = predicted_points.pop_front();
          if (out_mon.rotated_x !== want.x) begin
            mismatches++;
            $display("%0t: rotated_x expected %0d, got %0d",
                     $time, want.x, out_mon.rotated_x);
          end
          if (out_mon.rotated_y !== want.y) begin
            mismatches++;
            $display("%0t: rotated_y expected %0d, got %0d",
                     $time, want.y, out_mon.rotated_y);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predicted_points.push_back(rotate_about_pivot(in_mon.pivot_x, in_mon.pivot_y,
                                                      in_mon.point_x, in_mon.point_y,
                                                      in_mon.turn_angle));
    end
    pending = predicted_points.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the pivot rotation regression: clock, reset, input items, receiver stalls and
// the verdict. Depends on rpp_pkg, rpp_if, rotate_point_about_pivot_top, rpp_result_checker.
module testbench;

  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 235;
  localparam int SETTLE       = rpp_pkg::CORDIC_STAGES + 12;
  localparam int ONE          = 1 << rpp_pkg::GUARD_BITS;
  localparam int QUARTER      = rpp_pkg::QUARTER_TURN;
  localparam int HALF         = rpp_pkg::HALF_TURN;
  localparam int FULL         = rpp_pkg::FULL_TURN;

  localparam int COORD_MAX = (1 << (rpp_pkg::COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -(1 << (rpp_pkg::COORD_BITS - 1));
  localparam int ANGLE_MAX = (1 << (rpp_pkg::ANGLE_BITS - 1)) - 1;
  localparam int ANGLE_MIN = -(1 << (rpp_pkg::ANGLE_BITS - 1));

  typedef logic signed [rpp_pkg::COORD_BITS-1:0] coord_t;
  typedef logic signed [rpp_pkg::ANGLE_BITS-1:0] angle_t;
  typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

  logic clk;
  logic rst_n;

  rpp_in_if  in_ch ();
  rpp_out_if out_ch ();

  int         mismatch_count;
  int         results_pending;
  int         burst_left    = 0;
  bit         steady_source = 0;
  bit         long_hold_req = 0;
  sink_mode_t sink_mode     = SINK_MOSTLY;

  rotate_point_about_pivot_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rpp_result_checker u_result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: stall pattern per mode, or one long hold-off on request
  initial begin
    int tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (sink_mode)
          SINK_OPEN:     out_ch.ready <= 1'b1;
          SINK_MOSTLY:   out_ch.ready <= ($urandom_range(0, 9) < 7);
          SINK_PERIODIC: out_ch.ready <= ((tick % 7) != 2) && ((tick % 7) != 3);
          default:       out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
      tick++;
    end
  end

  // fields are cut to their port widths here; random patterns wrap on purpose
  task automatic send_item(input int pvx, pvy, ptx, pty, ang);
    int gap;
    if (!steady_source && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 20))
                                         : int'($urandom_range(0, 4));
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 24));
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.pivot_x    <= coord_t'(pvx);
    in_ch.pivot_y    <= coord_t'(pvy);
    in_ch.point_x    <= coord_t'(ptx);
    in_ch.point_y    <= coord_t'(pty);
    in_ch.turn_angle <= angle_t'(ang);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and hold until every outstanding item has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int pvx, pvy, ptx, pty;
    int ang;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        pvx = int'($urandom_range(0, 131071)) - 65536;
        pvy = int'($urandom_range(0, 131071)) - 65536;
        ptx = pvx + (int'($urandom_range(0, 8191)) - 4096);
        pty = pvy + (int'($urandom_range(0, 8191)) - 4096);
        ang = int'($urandom_range(0, 2 * FULL)) - FULL;
      end
      5, 6: begin
        pvx = int'($urandom());
        pvy = int'($urandom());
        ptx = int'($urandom());
        pty = int'($urandom());
        ang = int'($urandom());
      end
      7: begin
        // near the fold points: multiples of a right angle
        pvx = int'($urandom_range(0, 65535)) - 32768;
        pvy = int'($urandom_range(0, 65535)) - 32768;
        ptx = int'($urandom_range(0, 65535)) - 32768;
        pty = int'($urandom_range(0, 65535)) - 32768;
        k   = int'($urandom_range(0, 10)) - 5;
        ang = k * QUARTER + int'($urandom_range(0, 8)) - 4;
      end
      8: begin
        pvx = int'($urandom_range(0, 2097151)) - 1048576;
        pvy = int'($urandom_range(0, 2097151)) - 1048576;
        ptx = int'($urandom_range(0, 2097151)) - 1048576;
        pty = int'($urandom_range(0, 2097151)) - 1048576;
        ang = int'($urandom());
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          // far corners: drive the result past the coordinate range
          pvx = COORD_MAX - int'($urandom_range(0, 255));
          pvy = COORD_MIN + int'($urandom_range(0, 255));
          ptx = COORD_MIN + int'($urandom_range(0, 255));
          pty = COORD_MAX - int'($urandom_range(0, 255));
        end else begin
          pvx = int'($urandom());
          pvy = int'($urandom());
          ptx = pvx;
          pty = pvy;
        end
        ang = int'($urandom());
      end
    endcase
    send_item(pvx, pvy, ptx, pty, ang);
  endtask

  initial begin
    int phase, n;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.pivot_x    <= '0;
    in_ch.pivot_y    <= '0;
    in_ch.point_x    <= '0;
    in_ch.point_y    <= '0;
    in_ch.turn_angle <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: quadrants, wrap, fold edges, coordinate extremes
    sink_mode = SINK_MOSTLY;
    send_item(0, 0, ONE, 0, 0);
    send_item(0, 0, ONE, 0, QUARTER);
    send_item(0, 0, ONE, 0, -QUARTER);
    send_item(0, 0, ONE, ONE, HALF);
    send_item(0, 0, ONE, ONE, -HALF);
    send_item(ONE, -ONE, 3 * ONE, 5 * ONE, 3 * QUARTER);
    send_item(ONE, -ONE, 3 * ONE, 5 * ONE, FULL);
    send_item(-7 * ONE, 2 * ONE, 9 * ONE, -4 * ONE, ANGLE_MAX);
    send_item(-7 * ONE, 2 * ONE, 9 * ONE, -4 * ONE, ANGLE_MIN);
    send_item(100, 200, 5000, -3000, QUARTER + 1);
    send_item(100, 200, 5000, -3000, -QUARTER - 1);
    send_item(100, 200, 5000, -3000, QUARTER / 2);
    send_item(12345, -6789, 12345, -6789, QUARTER / 3);
    send_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, HALF);
    send_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0);
    send_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, HALF);
    send_item(0, 0, COORD_MAX, COORD_MAX, QUARTER / 2);
    send_item(0, 0, COORD_MIN, COORD_MIN, -QUARTER);
    send_item(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, -1);
    send_item(-1, -1, 1, 1, 1);
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      steady_source = (phase == 0);
      case (phase)
        0:       sink_mode = SINK_OPEN;
        1:       sink_mode = SINK_MOSTLY;
        2:       sink_mode = SINK_PERIODIC;
        default: sink_mode = SINK_SPARSE;
      endcase
      if (phase == 1) long_hold_req = 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) long_hold_req = 1;
        random_item();
      end
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
